@@ rtl/base64_encoder_custom_alphabet_top_macros.svh @@
// Assertion helpers shared by the encoder modules.
// Every macro expects aclk and aresetn in scope.
`ifndef BASE64_ENCODER_CUSTOM_ALPHABET_TOP_MACROS_SVH
`define BASE64_ENCODER_CUSTOM_ALPHABET_TOP_MACROS_SVH

// Property that must hold at every edge outside reset.
`define B64E_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication: trigger |-> consequence.
`define B64E_ASSERT_IMP(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: trigger |=> consequence.
`define B64E_ASSERT_NXT(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/b64e_pkg.sv @@
package b64e_pkg;

    localparam int unsigned SymWidth  = 6;
    localparam int unsigned CharWidth = 7;
    localparam int unsigned MaxSyms   = 4;
    localparam int unsigned IdxWidth  = $clog2(MaxSyms);

    typedef logic [SymWidth-1:0]  sym_t;
    typedef logic [CharWidth-1:0] char_t;
    typedef logic [IdxWidth-1:0]  idx_t;

    localparam logic [1:0] PhaseFirst  = 2'd0;
    localparam logic [1:0] PhaseSecond = 2'd1;
    localparam logic [1:0] PhaseThird  = 2'd2;

    // Symbols produced by one input byte; last_idx is the index of the final one.
    typedef struct packed {
        logic                     fin;
        idx_t                     last_idx;
        logic [MaxSyms-1:0][SymWidth-1:0] syms;
    } burst_t;

    // Alphabet: '.', '\', '0'-'9', 'A'-'Z', 'a'-'z'.
    function automatic char_t sym_to_char(input sym_t sym);
        char_t c;
        c = '0;
        if (sym == 6'd0) begin
            c = 7'h2E;
        end else if (sym == 6'd1) begin
            c = 7'h5C;
        end else if (sym inside {[6'd2:6'd11]}) begin
            c = 7'({1'b0, sym} + 7'h2E);
        end else if (sym inside {[6'd12:6'd37]}) begin
            c = 7'({1'b0, sym} + 7'h35);
        end else begin
            c = 7'({1'b0, sym} + 7'h3B);
        end
        return c;
    endfunction

endpackage

@@ rtl/base64_encoder_custom_alphabet_top.sv @@
// Path: an accepted byte is registered in the burst register, then each of its characters in
//   turn in the output register.
// Throughput: one character per cycle while m_tready is high; a byte holds the burst register
//   until all its characters move out (1 or 2, up to 4 on a final byte; about 4/3 on average).
// Reset (aresetn low, synchronous): group phase and leftover bits clear, both stages empty.
module base64_encoder_custom_alphabet_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tlast,   // run_last
    output logic [0:0] m_tuser    // [0] message_end
);

    logic             burst_valid;
    b64e_pkg::burst_t burst;
    logic             pop_last;
    b64e_pkg::char_t  out_char;
    logic             out_end;

    b64e_encode u_encode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_fin      (s_tlast),
        .pop_last    (pop_last),
        .burst_valid (burst_valid),
        .burst       (burst)
    );

    b64e_serial u_serial (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .burst_valid (burst_valid),
        .burst       (burst),
        .pop_last    (pop_last),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_char    (out_char),
        .out_last    (m_tlast),
        .out_end     (out_end)
    );

    assign m_tdata    = {1'b0, out_char};
    assign m_tuser[0] = out_end;

endmodule

@@ rtl/b64e_encode.sv @@
`include "base64_encoder_custom_alphabet_top_macros.svh"

module b64e_encode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_fin,
    input  logic              pop_last,
    output logic              burst_valid,
    output b64e_pkg::burst_t  burst
);

    logic [1:0]       phase_reg, phase_next;
    logic [3:0]       left_reg, left_next;
    logic             burst_valid_reg, burst_valid_next;
    b64e_pkg::burst_t burst_reg, burst_next;
    logic             accept;

    // Burst slot frees up in the same cycle its last symbol moves out.
    assign in_ready    = !burst_valid_reg || pop_last;
    assign accept      = in_valid && in_ready;
    assign burst_valid = burst_valid_reg;
    assign burst       = burst_reg;

    always_comb begin
        phase_next       = phase_reg;
        left_next        = left_reg;
        burst_next       = burst_reg;
        burst_valid_next = burst_valid_reg;
        if (pop_last) begin
            burst_valid_next = 1'b0;
        end
        if (accept) begin
            burst_valid_next = 1'b1;
            burst_next.fin   = in_fin;
            burst_next.syms  = '0;
            case (phase_reg)
                b64e_pkg::PhaseSecond: begin
                    burst_next.syms[0] = {left_reg[1:0], in_byte[7:4]};
                    if (in_fin) begin
                        burst_next.syms[1] = {in_byte[3:0], 2'b00};
                    end
                    burst_next.last_idx = in_fin ? 2'd2 : 2'd0;
                    left_next           = in_byte[3:0];
                    phase_next          = b64e_pkg::PhaseThird;
                end
                b64e_pkg::PhaseThird: begin
                    burst_next.syms[0]  = {left_reg, in_byte[7:6]};
                    burst_next.syms[1]  = in_byte[5:0];
                    burst_next.last_idx = 2'd1;
                    left_next           = '0;
                    phase_next          = b64e_pkg::PhaseFirst;
                end
                default: begin
                    burst_next.syms[0] = in_byte[7:2];
                    if (in_fin) begin
                        burst_next.syms[1] = {in_byte[1:0], 4'b0000};
                    end
                    burst_next.last_idx = in_fin ? 2'd3 : 2'd0;
                    left_next           = {2'b00, in_byte[1:0]};
                    phase_next          = b64e_pkg::PhaseSecond;
                end
            endcase
            // Final byte: restart grouping for the next message.
            if (in_fin) begin
                phase_next = b64e_pkg::PhaseFirst;
                left_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= b64e_pkg::PhaseFirst;
            left_reg        <= '0;
            burst_valid_reg <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            left_reg        <= left_next;
            burst_valid_reg <= burst_valid_next;
        end
        burst_reg <= burst_next;
    end

    `B64E_ASSERT(a_phase_legal, phase_reg != 2'd3, "group phase reached an unused code")
    `B64E_ASSERT_NXT(a_fin_restarts, accept && in_fin,
        phase_reg == b64e_pkg::PhaseFirst && left_reg == 4'd0, "final byte left state behind")
    `B64E_ASSERT_NXT(a_burst_holds, burst_valid_reg && !pop_last,
        burst_valid_reg && $stable(burst_reg), "pending burst changed before it drained")

endmodule

@@ rtl/b64e_serial.sv @@
`include "base64_encoder_custom_alphabet_top_macros.svh"

module b64e_serial (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 burst_valid,
    input  b64e_pkg::burst_t     burst,
    output logic                 pop_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output b64e_pkg::char_t      out_char,
    output logic                 out_last,
    output logic                 out_end
);

    b64e_pkg::idx_t  idx_reg, idx_next;
    logic            valid_reg, valid_next;
    b64e_pkg::char_t char_reg, char_next;
    logic            last_reg, last_next;
    logic            end_reg, end_next;
    logic            pop;
    logic            at_last;

    assign pop      = burst_valid && (!valid_reg || out_ready);
    assign at_last  = idx_reg == burst.last_idx;
    assign pop_last = pop && at_last;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_end   = end_reg;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        end_next   = end_reg;
        if (pop) begin
            valid_next = 1'b1;
            char_next  = b64e_pkg::sym_to_char(burst.syms[idx_reg]);
            last_next  = at_last;
            end_next   = at_last && burst.fin;
            idx_next   = at_last ? '0 : b64e_pkg::idx_t'(idx_reg + 1'b1);
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
        char_reg <= char_next;
        last_reg <= last_next;
        end_reg  <= end_next;
    end

    `B64E_ASSERT_IMP(a_end_is_last, valid_reg && end_reg, last_reg,
        "message end flagged on a beat that does not close its byte")
    `B64E_ASSERT_IMP(a_idx_in_burst, burst_valid, idx_reg <= burst.last_idx,
        "symbol index ran past the burst")
    `B64E_ASSERT_NXT(a_idx_wraps, pop_last, idx_reg == 2'd0,
        "symbol index not rewound after the burst drained")

endmodule

@@ tb/b64e_char_checker.sv @@
`timescale 1ns / 100ps

module b64e_char_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // final_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [6:0] out_char, [7] zero
    input  logic        m_tlast,    // run_last
    input  logic [0:0]  m_tuser,    // [0] message_end
    output int unsigned mismatch_count,
    output int unsigned pending_chars,
    output int unsigned chars_checked
);

    // Symbol 0 sits in the top byte of the literal.
    localparam logic [64*8-1:0] AlphabetChars =
        ".\\0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

    typedef struct packed {
        b64e_pkg::char_t ch;
        logic            run_end;
        logic            msg_end;
    } enc_char_t;

    enc_char_t  expected_chars[$];
    logic [1:0] group_phase;
    logic [3:0] leftover_bits;

    initial begin
        mismatch_count = 0;
        pending_chars  = 0;
        chars_checked  = 0;
        group_phase    = b64e_pkg::PhaseFirst;
        leftover_bits  = '0;
    end

    task automatic encode_byte(input logic [7:0] data, input logic fin);
        b64e_pkg::sym_t syms [b64e_pkg::MaxSyms];
        int             n;
        enc_char_t      c;
        n = 0;
        syms[1] = '0;
        syms[2] = '0;
        syms[3] = '0;
        case (group_phase)
            b64e_pkg::PhaseSecond: begin
                syms[0] = {leftover_bits[1:0], data[7:4]};
                n = 1;
                if (fin) begin
                    syms[1] = {data[3:0], 2'b00};
                    n = 3;
                end
                leftover_bits = data[3:0];
                group_phase   = b64e_pkg::PhaseThird;
            end
            b64e_pkg::PhaseThird: begin
                syms[0] = {leftover_bits, data[7:6]};
                syms[1] = data[5:0];
                n = 2;
                leftover_bits = '0;
                group_phase   = b64e_pkg::PhaseFirst;
            end
            default: begin
                syms[0] = data[7:2];
                n = 1;
                if (fin) begin
                    syms[1] = {data[1:0], 4'b0000};
                    n = 4;
                end
                leftover_bits = {2'b00, data[1:0]};
                group_phase   = b64e_pkg::PhaseSecond;
            end
        endcase
        // A final byte closes the message: restart the group
        if (fin) begin
            group_phase   = b64e_pkg::PhaseFirst;
            leftover_bits = '0;
        end
        for (int i = 0; i < n; i++) begin
            c.ch      = AlphabetChars[(63 - int'(syms[i])) * 8 +: b64e_pkg::CharWidth];
            c.run_end = (i == n - 1);
            c.msg_end = fin && (i == n - 1);
            expected_chars.push_back(c);
        end
    endtask

    task automatic check_char();
        enc_char_t want;
        if (expected_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: unexpected beat tdata=%h tlast=%b tuser=%b",
                         $realtime, m_tdata, m_tlast, m_tuser);
        end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (m_tdata !== {1'b0, want.ch} || m_tlast !== want.run_end ||
                    m_tuser[0] !== want.msg_end) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: char %0d expected tdata=%h tlast=%b tuser=%b, got %h %b %b",
                             $realtime, chars_checked, {1'b0, want.ch}, want.run_end,
                             want.msg_end, m_tdata, m_tlast, m_tuser);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_chars.delete();
            group_phase   = b64e_pkg::PhaseFirst;
            leftover_bits = '0;
        end else begin
            if (m_tvalid && m_tready)
                check_char();
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);
        end
        pending_chars = expected_chars.size();
    end

endmodule

@@ tb/tb_base64_encoder_custom_alphabet_top.sv @@
`timescale 1ns / 100ps

module tb_base64_encoder_custom_alphabet_top;

    localparam int unsigned CycleLimit   = 400_000;
    localparam int unsigned ByteTarget   = 460;
    localparam int unsigned HoldCycles   = 250;
    localparam int unsigned HoldAfterByte = 150;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    int unsigned mismatch_count;
    int unsigned pending_chars;
    int unsigned chars_checked;
    int unsigned bytes_sent;
    int unsigned messages_sent;
    int unsigned cycle_count;
    logic        hold_active;
    logic        tx_idle_on;

    base64_encoder_custom_alphabet_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    b64e_char_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_chars  (pending_chars),
        .chars_checked  (chars_checked)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Offer one byte after a random gap, hold it until the beat is taken.
    task automatic send_byte(input logic [7:0] data, input logic fin);
        int unsigned gap;
        if ($urandom_range(0, 19) == 0)
            tx_idle_on = ~tx_idle_on;
        gap = tx_idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        if (fin)
            messages_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_byte(pick_byte(), i == len - 1);
    endtask

    // Stimulus
    initial begin
        logic [7:0] pattern [5];
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        bytes_sent    = 0;
        messages_sent = 0;
        tx_idle_on    = 1'b1;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Message ends on each phase, with all-zero and all-one bytes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        pattern = '{8'h01, 8'h80, 8'h3F, 8'hC0, 8'hFC};
        for (int i = 0; i < 5; i++)
            send_byte(pattern[i], i == 4);

        // Random messages, mostly short, a few long ones
        while (bytes_sent < ByteTarget) begin
            if ($urandom_range(0, 9) == 0)
                send_message($urandom_range(13, 40));
            else
                send_message($urandom_range(1, 12));
        end
        s_tvalid <= 1'b0;

        @(negedge aclk);
        while (pending_chars != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Sent %0d messages (%0d bytes), checked %0d encoded characters",
                 messages_sent, bytes_sent, chars_checked);
        $display("Receiver held off once for %0d cycles mid-run", HoldCycles);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver: random stalls after beats in idle phases, plus the long hold-off
    initial begin
        int unsigned rx_stall;
        logic        took;
        logic        rx_idle_on;
        m_tready   = 1'b0;
        rx_stall   = 0;
        rx_idle_on = 1'b1;
        forever begin
            @(posedge aclk);
            took = m_tvalid && m_tready;
            @(negedge aclk);
            if (took) begin
                if ($urandom_range(0, 24) == 0)
                    rx_idle_on = ~rx_idle_on;
                rx_stall = rx_idle_on ? $urandom_range(0, 16) : 0;
            end
            if (hold_active || !aresetn) begin
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so the encoder backs up into its input
    initial begin
        hold_active = 1'b0;
        @(negedge aclk);
        while (bytes_sent < HoldAfterByte) @(negedge aclk);
        hold_active = 1'b1;
        repeat (HoldCycles) @(negedge aclk);
        hold_active = 1'b0;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d characters still expected",
                 cycle_count, pending_chars);
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/b64e_pkg.sv
rtl/b64e_encode.sv
rtl/b64e_serial.sv
rtl/base64_encoder_custom_alphabet_top.sv
tb/b64e_char_checker.sv
tb/tb_base64_encoder_custom_alphabet_top.sv
